// ===== hw/rtl/cps_pkg.sv =====
// Shared types, pattern constants and byte classifiers for the credential pattern scanner.
// Used by cps_scan_core and credential_pattern_scanner; depends on nothing else.

package cps_pkg;

    // One request on the input channel.
    typedef struct packed {
        logic [7:0] text_byte;
        logic       byte_present;
        logic       end_of_text;
    } cps_item_t;

    // Progress of the AKIA checker: looking for the first AKIA, checking its tail, or settled.
    typedef enum logic [1:0] {
        AK_SEARCH = 2'd0,
        AK_TAIL   = 2'd1,
        AK_DONE   = 2'd2
    } akia_phase_t;

    // Complete per-string scan state.
    typedef struct packed {
        akia_phase_t akia_phase;
        logic [1:0]  akia_progress;
        logic [4:0]  akia_tail_count;
        logic        akia_found;
        logic [1:0]  ghp_progress;
        logic        ghp_found;
        logic [1:0]  sk_progress;
        logic        sk_found;
        logic [3:0]  begin_progress;
        logic        begin_found;
        logic [3:0]  privkey_progress;
        logic        privkey_found;
        logic [7:0]  blob_run;
        logic        blob_found;
    } scan_state_t;

    localparam logic [7:0] MIN_BLOB_RUN_RESET = 8'd32;
    localparam logic [4:0] AKIA_TAIL_LEN      = 5'd16;
    localparam logic [7:0] BLOB_RUN_MAX       = 8'hFF;

    // Pattern lengths, as values the 4-bit progress counters reach on a full match.
    localparam logic [3:0] LEN_AKIA    = 4'd4;
    localparam logic [3:0] LEN_GHP     = 4'd4;
    localparam logic [3:0] LEN_SK      = 4'd3;
    localparam logic [3:0] LEN_BEGIN   = 4'd10;
    localparam logic [3:0] LEN_PRIVKEY = 4'd11;

    // The dash run of "-----BEGIN" is the only prefix that overlaps itself.
    localparam logic [3:0] BEGIN_DASH_RUN = 4'd5;
    localparam logic [7:0] CHAR_DASH      = 8'h2D;

    localparam logic [7:0] PAT_AKIA [4] = '{8'h41, 8'h4B, 8'h49, 8'h41};
    localparam logic [7:0] PAT_GHP  [4] = '{8'h67, 8'h68, 8'h70, 8'h5F};
    localparam logic [7:0] PAT_SK   [3] = '{8'h73, 8'h6B, 8'h2D};
    localparam logic [7:0] PAT_BEGIN [10] = '{8'h2D, 8'h2D, 8'h2D, 8'h2D, 8'h2D,
                                              8'h42, 8'h45, 8'h47, 8'h49, 8'h4E};
    localparam logic [7:0] PAT_PRIVKEY [11] = '{8'h50, 8'h52, 8'h49, 8'h56, 8'h41, 8'h54,
                                                8'h45, 8'h20, 8'h4B, 8'h45, 8'h59};

    // One step of a prefix matcher whose pattern repeats its first character nowhere
    // at a border: extend on a match, otherwise restart on the first character.
    function automatic logic [3:0] match_step(input logic [3:0] s, input logic [7:0] c,
                                              input logic [7:0] pat_at_s,
                                              input logic [7:0] pat_first);
        logic [3:0] nxt;
        if (c == pat_at_s) begin
            nxt = s + 4'd1;
        end else if (c == pat_first) begin
            nxt = 4'd1;
        end else begin
            nxt = 4'd0;
        end
        return nxt;
    endfunction

    function automatic logic is_upper_or_digit(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h30) && (c <= 8'h39));
    endfunction

    // Letters, digits and the base64 / underscore punctuation.
    function automatic logic is_key_like(input logic [7:0] c);
        return is_upper_or_digit(c) || ((c >= 8'h61) && (c <= 8'h7A)) ||
               (c == 8'h2F) || (c == 8'h2B) || (c == 8'h3D) || (c == 8'h5F);
    endfunction

endpackage

// ===== hw/rtl/cps_scan_core.sv =====
// Per-string scan state and its one-byte update for the credential pattern scanner.
// Depends on cps_pkg for the item and state types, patterns and byte classifiers.

module cps_scan_core import cps_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step,          // consume item this cycle
    input  cps_item_t  item,
    input  logic [7:0] min_blob_run,
    output logic       hit            // verdict for the string, valid when item ends it
);

    scan_state_t st_reg;
    scan_state_t st_next;
    scan_state_t scan;

    logic [7:0] c;
    logic [3:0] akia_s;
    logic [3:0] ghp_s;
    logic [3:0] sk_s;
    logic [3:0] begin_s;
    logic [3:0] privkey_s;
    logic [4:0] tail_inc;
    logic [7:0] run_inc;

    assign c = item.text_byte;

    // Next prefix position of each matcher for this byte.
    always_comb begin
        akia_s    = match_step({2'b00, st_reg.akia_progress}, c,
                               PAT_AKIA[st_reg.akia_progress], PAT_AKIA[0]);
        ghp_s     = match_step({2'b00, st_reg.ghp_progress}, c,
                               PAT_GHP[st_reg.ghp_progress], PAT_GHP[0]);
        sk_s      = match_step({2'b00, st_reg.sk_progress}, c,
                               PAT_SK[st_reg.sk_progress], PAT_SK[0]);
        privkey_s = match_step(st_reg.privkey_progress, c,
                               PAT_PRIVKEY[st_reg.privkey_progress], PAT_PRIVKEY[0]);
        // A sixth dash keeps the last five dashes as a matched prefix.
        if ((st_reg.begin_progress == BEGIN_DASH_RUN) && (c == CHAR_DASH)) begin
            begin_s = BEGIN_DASH_RUN;
        end else begin
            begin_s = match_step(st_reg.begin_progress, c,
                                 PAT_BEGIN[st_reg.begin_progress], PAT_BEGIN[0]);
        end
        tail_inc = st_reg.akia_tail_count + 5'd1;
        run_inc  = (st_reg.blob_run == BLOB_RUN_MAX) ? st_reg.blob_run
                                                     : st_reg.blob_run + 8'd1;
    end

    // State after scanning the byte, the verdict, and the clear after an end item.
    always_comb begin
        scan = st_reg;
        if (item.byte_present) begin
            case (st_reg.akia_phase)
                AK_SEARCH: begin
                    if (akia_s == LEN_AKIA) begin
                        scan.akia_phase      = AK_TAIL;
                        scan.akia_progress   = 2'd0;
                        scan.akia_tail_count = 5'd0;
                    end else begin
                        scan.akia_progress = akia_s[1:0];
                    end
                end
                AK_TAIL: begin
                    if (is_upper_or_digit(c)) begin
                        scan.akia_tail_count = tail_inc;
                        if (tail_inc >= AKIA_TAIL_LEN) begin
                            scan.akia_found = 1'b1;
                            scan.akia_phase = AK_DONE;
                        end
                    end else begin
                        scan.akia_phase = AK_DONE;
                    end
                end
                default: begin
                end
            endcase

            if (ghp_s == LEN_GHP) begin
                scan.ghp_found    = 1'b1;
                scan.ghp_progress = 2'd0;
            end else begin
                scan.ghp_progress = ghp_s[1:0];
            end

            if (sk_s == LEN_SK) begin
                scan.sk_found    = 1'b1;
                scan.sk_progress = 2'd0;
            end else begin
                scan.sk_progress = sk_s[1:0];
            end

            if (begin_s == LEN_BEGIN) begin
                scan.begin_found    = 1'b1;
                scan.begin_progress = 4'd0;
            end else begin
                scan.begin_progress = begin_s;
            end

            if (privkey_s == LEN_PRIVKEY) begin
                scan.privkey_found    = 1'b1;
                scan.privkey_progress = 4'd0;
            end else begin
                scan.privkey_progress = privkey_s;
            end

            if (is_key_like(c)) begin
                scan.blob_run = run_inc;
                if (run_inc >= min_blob_run) begin
                    scan.blob_found = 1'b1;
                end
            end else begin
                scan.blob_run = 8'd0;
            end
        end

        hit = scan.akia_found | scan.ghp_found | scan.sk_found |
              (scan.begin_found & scan.privkey_found) | scan.blob_found |
              (scan.blob_run >= min_blob_run);

        st_next = st_reg;
        if (step) begin
            st_next = item.end_of_text ? scan_state_t'('0) : scan;
        end
    end

    // Scan state register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= scan_state_t'('0);
        end else begin
            st_reg <= st_next;
        end
    end

endmodule

// ===== hw/rtl/credential_pattern_scanner.sv =====
// Top level of the credential pattern scanner: input register, scan core, result register.
// Depends on cps_pkg and cps_scan_core.
//
// Usage:
//   A string enters on the s_ stream one byte per request. s_tdata carries the byte,
//   s_tuser says whether the byte is valid (0 for an end-only request such as an empty
//   string), and s_tlast marks the last request of the string. For each request with
//   s_tlast high one result leaves on the m_ stream; m_tdata[0] is 1 when the string
//   held an AKIA key, a ghp_ or sk- token, a private key header, or a key-like run of
//   at least min_blob_run bytes. Other requests produce no result. min_blob_run must be
//   written through cfg_valid / cfg_data only while no string is in flight; not enforced.
// Timing:
//   One request is accepted every cycle while s_tready is high. An accepted end request
//   sits in the input register while the scan core forms the verdict, which is loaded
//   into the result register that drives m_tvalid. The result register holds a single
//   result.
//   When the receiver stalls, the result register holds its result and the input
//   register keeps passing bytes; an end request waits in the input register until
//   the result register is free, and s_tready stays low while it waits.
// Reset:
//   aresetn (synchronous, active low) empties both registers, clears the scan state and
//   sets min_blob_run to 32.

module credential_pattern_scanner import cps_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,     // [7:0] text_byte
    input  logic       s_tuser,     // [0] byte_present
    input  logic       s_tlast,     // end_of_text
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,     // [0] secret_found, [7:1] zero
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data     // min_blob_run
);

    logic       in_valid_reg;
    logic       in_valid_next;
    cps_item_t  in_item_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_found_reg;
    logic [7:0] min_blob_run_reg;
    logic       out_free;
    logic       in_fire;
    logic       s_fire;
    logic       core_hit;

    // Handshake: an end request moves on only when the result register has room.
    assign out_free  = !out_valid_reg || m_tready;
    assign in_fire   = in_valid_reg && (!in_item_reg.end_of_text || out_free);
    assign s_tready  = !in_valid_reg || in_fire;
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign in_valid_next = s_fire ? 1'b1 : (in_fire ? 1'b0 : in_valid_reg);

    always_comb begin
        out_valid_next = out_valid_reg;
        if (in_fire && in_item_reg.end_of_text) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // Valid flags and the configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            min_blob_run_reg <= MIN_BLOB_RUN_RESET;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready) begin
                min_blob_run_reg <= cfg_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_item_reg.text_byte    <= s_tdata;
            in_item_reg.byte_present <= s_tuser;
            in_item_reg.end_of_text  <= s_tlast;
        end
        if (in_fire && in_item_reg.end_of_text) begin
            out_found_reg <= core_hit;
        end
    end

    cps_scan_core u_scan (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (in_fire),
        .item         (in_item_reg),
        .min_blob_run (min_blob_run_reg),
        .hit          (core_hit)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_found_reg};

endmodule
